// ===== rtl/bnms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnms_pkg
// Shared constants and controller/datapath interface types for the box
// non-maximum suppression block.
// ----------------------------------------------------------------------------
package bnms_pkg;

    localparam int MAX_BOXES_DEF  = 32;
    localparam int COORD_BITS_DEF = 12;
    localparam int THR_W          = 16;
    localparam logic [THR_W-1:0] THR_RESET = 16'd32768;

    typedef struct packed {
        logic load;       // input transaction accepted
        logic start;      // start a scan over the stored boxes
        logic mode_supp;  // scan kind: 1 suppression, 0 max-area search
        logic fetch;      // read best box, mark it done
        logic capt;       // capture fetched box as current
        logic out_load;   // load output register with current box
        logic out_last;   // run_last for the loaded result
        logic clear;      // end of batch
    } t_cmd;

    typedef struct packed {
        logic busy;       // scan issuing or pipeline not drained
        logic found;      // max-area search found an open box
        logic out_free;   // output register can take a result
    } t_status;

endpackage

// ===== rtl/bnms_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnms_dp
// Datapath: box memory, done flags, five-stage scan pipeline shared by the
// max-area search and the IoU suppression pass, output register.
// ----------------------------------------------------------------------------
module bnms_dp #(
    parameter int MAX_BOXES  = bnms_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = bnms_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bnms_pkg::t_cmd              i_cmd,
    output bnms_pkg::t_status           o_sts,
    input  logic [4*COORD_BITS-1:0]     i_in_data,
    input  logic                        i_cfg_we,
    input  logic [bnms_pkg::THR_W-1:0]  i_cfg_wdata,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [4*COORD_BITS-1:0]     o_out_data,
    output logic                        o_out_last,
    output logic                        o_out_ovf
);

    localparam int CB = COORD_BITS;
    localparam int BW = 4*CB;
    localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW = $clog2(MAX_BOXES + 1);
    localparam int AW = 2*CB;
    localparam int UW = AW + 1;
    localparam int PW = bnms_pkg::THR_W + UW;

    logic [BW-1:0]  mem [MAX_BOXES];
    logic [MAX_BOXES-1:0] r_done;

    logic [bnms_pkg::THR_W-1:0] r_thr;
    logic [CW-1:0]  r_cnt;
    logic           r_ovf;

    logic           r_issue, r_supp;
    logic [IW-1:0]  r_idx, r_bidx;
    logic [IW-1:0]  rd_addr;
    logic [BW-1:0]  r_rd, r_cur;
    logic [AW-1:0]  r_cur_area;

    logic           r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [IW-1:0]  r_i1, r_i2, r_i3, r_i4, r_i5;
    logic [AW-1:0]  r_area2, r_area3, r_best;
    logic [CB-1:0]  r_wi2, r_hi2;
    logic [AW-1:0]  r_inter3, r_inter4, r_inter5;
    logic [UW-1:0]  r_uni4;
    logic [PW-1:0]  r_prod5;
    logic           r_found;

    logic           r_out_valid, r_out_last, r_out_ovf;
    logic [BW-1:0]  r_out_data;

    // box fields: x lowest, then y, width, height
    logic [CB-1:0]  ax, ay, aw, ah, bx, by, bw, bh;
    logic [CB:0]    x1, y1, x2, y2, ax2, bx2, ay2, by2;
    logic [CB-1:0]  wi, hi;
    logic           last_idx, out_free;

    assign ax = r_cur[CB-1:0];
    assign ay = r_cur[2*CB-1:CB];
    assign aw = r_cur[3*CB-1:2*CB];
    assign ah = r_cur[4*CB-1:3*CB];
    assign bx = r_rd[CB-1:0];
    assign by = r_rd[2*CB-1:CB];
    assign bw = r_rd[3*CB-1:2*CB];
    assign bh = r_rd[4*CB-1:3*CB];

    // overlap never exceeds either width or height, so CB bits hold it
    always_comb begin
        x1  = (ax > bx) ? {1'b0, ax} : {1'b0, bx};
        y1  = (ay > by) ? {1'b0, ay} : {1'b0, by};
        ax2 = {1'b0, ax} + {1'b0, aw};
        bx2 = {1'b0, bx} + {1'b0, bw};
        ay2 = {1'b0, ay} + {1'b0, ah};
        by2 = {1'b0, by} + {1'b0, bh};
        x2  = (ax2 < bx2) ? ax2 : bx2;
        y2  = (ay2 < by2) ? ay2 : by2;
        wi  = (x2 > x1) ? CB'(x2 - x1) : '0;
        hi  = (y2 > y1) ? CB'(y2 - y1) : '0;
    end

    assign rd_addr  = r_issue ? r_idx : r_bidx;
    assign last_idx = (r_idx == IW'(r_cnt - CW'(1)));
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_cnt < CW'(MAX_BOXES))) begin
            mem[r_cnt[IW-1:0]] <= i_in_data;
        end
        r_rd <= mem[rd_addr];
    end

    // payload pipeline
    always_ff @(posedge i_clk) begin
        r_i1       <= r_idx;
        r_i2       <= r_i1;
        r_i3       <= r_i2;
        r_i4       <= r_i3;
        r_i5       <= r_i4;
        r_area2    <= bw * bh;
        r_wi2      <= wi;
        r_hi2      <= hi;
        r_inter3   <= r_wi2 * r_hi2;
        r_area3    <= r_area2;
        r_inter4   <= r_inter3;
        r_uni4     <= {1'b0, r_cur_area} + {1'b0, r_area3} - {1'b0, r_inter3};
        r_inter5   <= r_inter4;
        r_prod5    <= r_thr * r_uni4;
        r_cur_area <= aw * ah;
        if (i_cmd.capt) begin
            r_cur <= r_rd;
        end
        if (i_cmd.out_load) begin
            r_out_data <= r_cur;
            r_out_last <= i_cmd.out_last;
            r_out_ovf  <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= bnms_pkg::THR_RESET;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_done      <= '0;
            r_issue     <= 1'b0;
            r_supp      <= 1'b0;
            r_idx       <= '0;
            r_bidx      <= '0;
            r_best      <= '0;
            r_found     <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                if (r_cnt < CW'(MAX_BOXES)) begin
                    r_cnt <= r_cnt + CW'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end

            r_v1 <= r_issue && !r_done[r_idx];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;

            if (i_cmd.start) begin
                r_issue <= 1'b1;
                r_idx   <= '0;
                r_supp  <= i_cmd.mode_supp;
                r_found <= 1'b0;
            end else if (r_issue) begin
                if (last_idx) begin
                    r_issue <= 1'b0;
                end else begin
                    r_idx <= r_idx + IW'(1);
                end
            end

            // strict compare keeps the earliest box among equal areas
            if (!r_supp && r_v2 && (!r_found || (r_area2 > r_best))) begin
                r_found <= 1'b1;
                r_best  <= r_area2;
                r_bidx  <= r_i2;
            end

            if (r_supp && r_v5 && ({1'b0, r_inter5, 16'b0} > r_prod5)) begin
                r_done[r_i5] <= 1'b1;
            end

            if (i_cmd.fetch) begin
                r_done[r_bidx] <= 1'b1;
            end

            if (i_cmd.clear) begin
                r_cnt  <= '0;
                r_ovf  <= 1'b0;
                r_done <= '0;
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.busy     = r_issue || r_v1 || r_v2 || r_v3 || r_v4 || r_v5;
    assign o_sts.found    = r_found;
    assign o_sts.out_free = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;
    assign o_out_ovf   = r_out_ovf;

endmodule

// ===== rtl/bnms_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bnms_ctrl
// Controller: batch loading, alternating max-area search and suppression
// scans, and hand-off of each kept box to the output register.
// ----------------------------------------------------------------------------
module bnms_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_last,
    output logic                o_in_ready,
    input  bnms_pkg::t_status   i_sts,
    output bnms_pkg::t_cmd      o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FIND  = 6'b000010,
        ST_FETCH = 6'b000100,
        ST_CAPT  = 6'b001000,
        ST_SUPP  = 6'b010000,
        ST_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_pend, n_pend;

    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_FIND;
                end
            end
            ST_FIND: begin
                if (!i_sts.busy) begin
                    if (r_pend) begin
                        n_state = ST_OUT;
                    end else if (i_sts.found) begin
                        n_state = ST_FETCH;
                    end else begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_CAPT;
            end
            ST_CAPT: begin
                o_cmd.capt      = 1'b1;
                o_cmd.start     = 1'b1;
                o_cmd.mode_supp = 1'b1;
                n_pend          = 1'b1;
                n_state         = ST_SUPP;
            end
            ST_SUPP: begin
                if (!i_sts.busy) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_FIND;
                end
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = !i_sts.found;
                    n_pend         = 1'b0;
                    if (i_sts.found) begin
                        n_state = ST_FETCH;
                    end else begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_pend  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

endmodule

// ===== rtl/box_non_max_suppression.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_non_max_suppression
// Greedy IoU non-maximum suppression over a batch of boxes.
// ----------------------------------------------------------------------------
// Boxes arrive on the s_axis channel, one per transaction; tlast ends the
// batch. Up to MAX_BOXES boxes are stored, later ones are dropped and the
// batch's results carry overflow in m_axis_tuser.
// Loading accepts one box per cycle. After tlast the block runs one max-area
// search, then per kept box a fetch, a capture, a suppression pass, the next
// search and the output load. Each scan covers the n stored boxes through a
// five-stage pipeline.
// s_axis_tready is low from tlast until the final kept box is loaded in the
// output register. m_axis_tlast marks the final kept box of the batch.
// A stalled receiver holds the result in the output register and the
// processing waits for it; nothing is lost.
// Threshold writes via i_cfg_we/i_cfg_wdata take effect at once and should
// come while no batch is in flight.
// Reset (i_rst_n low, synchronous) empties the store, clears the output
// and sets the threshold to 0.5 (32768).
// ----------------------------------------------------------------------------
module box_non_max_suppression #(
    parameter int MAX_BOXES  = bnms_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = bnms_pkg::COORD_BITS_DEF,
    localparam int TDATA_W   = ((4*COORD_BITS + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bnms_pkg::THR_W-1:0]  i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // box_x, box_y, box_width, box_height, zero pad
    input  logic [TDATA_W-1:0]          s_axis_tdata,
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // kept_x, kept_y, kept_width, kept_height, zero pad
    output logic [TDATA_W-1:0]          m_axis_tdata,
    output logic                        m_axis_tlast,
    // overflow
    output logic                        m_axis_tuser
);

    bnms_pkg::t_cmd    cmd;
    bnms_pkg::t_status sts;
    logic [4*COORD_BITS-1:0] out_data;

    bnms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bnms_dp #(
        .MAX_BOXES  (MAX_BOXES),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata[4*COORD_BITS-1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (out_data),
        .o_out_last  (m_axis_tlast),
        .o_out_ovf   (m_axis_tuser)
    );

    assign m_axis_tdata = TDATA_W'(out_data);

endmodule
